FILE: sv/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

	localparam int MAP_PAGES   = 16384;
	localparam int WORD_W      = 64;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int NUM_WORDS   = MAP_PAGES / WORD_W;
	localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
	localparam int WIDX_W      = WORD_IDX_W + 1;
	localparam int PAGE_W      = $clog2(MAP_PAGES);

	localparam int MODE_W      = 2;
	localparam int START_W     = 14;
	localparam int COUNT_W     = 15;
	localparam int STATUS_W    = 2;
	localparam int LIMIT_W     = 15;
	localparam int PG_W        = ((PAGE_W > COUNT_W) ? PAGE_W : COUNT_W) + 1;
	localparam int START_LIMIT = 1 << START_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD   = 2'd0,
		MODE_MARK  = 2'd1,
		MODE_ALLOC = 2'd2,
		MODE_FREE  = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_NOFIT = 2'd1,
		STAT_ZERO  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RANGE,
		S_WR_RD,
		S_WR_WR,
		S_AL_CHK,
		S_SC_RD,
		S_SC_LD,
		S_SC_EV,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    load_req;
		logic    range_set;
		logic    sc_start;
		logic    rd_word;
		logic    wr_word;
		logic    sc_load;
		logic    sc_eval;
		logic    pend_we;
		status_t pend_code;
		logic    res_load;
	} cmd_t;

	typedef struct packed {
		logic in_alloc;
		logic empty;
		logic wr_last;
		logic cnt_zero;
		logic too_big;
		logic sc_end;
		logic found;
		logic far;
		logic ev_next;
	} stat_t;

endpackage

`default_nettype wire

FILE: sv/bpa_req_if.sv
`default_nettype none

interface bpa_req_if;
	logic                         valid;
	logic                         ready;
	logic [bpa_pkg::MODE_W-1:0]   mode;
	logic [bpa_pkg::START_W-1:0]  first_page;
	logic [bpa_pkg::COUNT_W-1:0]  page_count;

	modport source (output valid, output mode, output first_page, output page_count,
		input ready);
	modport sink (input valid, input mode, input first_page, input page_count,
		output ready);
endinterface

`default_nettype wire

FILE: sv/bpa_rsp_if.sv
`default_nettype none

interface bpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bpa_pkg::STATUS_W-1:0]  status;
	logic [bpa_pkg::START_W-1:0]   alloc_page;

	modport source (output valid, output status, output alloc_page, input ready);
	modport sink (input valid, input status, input alloc_page, output ready);
endinterface

`default_nettype wire

FILE: sv/bpa_ctrl.sv
`default_nettype none

module bpa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire logic           rsp_ready,
	output logic                rsp_valid,
	input  wire bpa_pkg::stat_t stat,
	output bpa_pkg::cmd_t       cmd
);

	bpa_pkg::state_t state_q;
	bpa_pkg::state_t state_d;
	logic            rsp_valid_q;
	logic            out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign req_ready = (state_q == bpa_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpa_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = stat.in_alloc ? bpa_pkg::S_AL_CHK : bpa_pkg::S_RANGE;
				end
			end
			bpa_pkg::S_RANGE: begin
				state_d = stat.empty ? bpa_pkg::S_RESP : bpa_pkg::S_WR_RD;
			end
			bpa_pkg::S_WR_RD: begin
				state_d = bpa_pkg::S_WR_WR;
			end
			bpa_pkg::S_WR_WR: begin
				state_d = stat.wr_last ? bpa_pkg::S_RESP : bpa_pkg::S_WR_RD;
			end
			bpa_pkg::S_AL_CHK: begin
				state_d = (stat.cnt_zero || stat.too_big) ? bpa_pkg::S_RESP : bpa_pkg::S_SC_RD;
			end
			bpa_pkg::S_SC_RD: begin
				state_d = stat.sc_end ? bpa_pkg::S_RESP : bpa_pkg::S_SC_LD;
			end
			bpa_pkg::S_SC_LD: begin
				state_d = bpa_pkg::S_SC_EV;
			end
			bpa_pkg::S_SC_EV: begin
				priority if (stat.found) begin
					state_d = stat.far ? bpa_pkg::S_RESP : bpa_pkg::S_RANGE;
				end else if (stat.ev_next) begin
					state_d = bpa_pkg::S_SC_RD;
				end else begin
					state_d = bpa_pkg::S_SC_EV;
				end
			end
			bpa_pkg::S_RESP: begin
				if (out_free) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpa_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.pend_code = bpa_pkg::STAT_DONE;
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				cmd.load_req = req_valid;
			end
			bpa_pkg::S_RANGE: begin
				cmd.range_set = 1'b1;
			end
			bpa_pkg::S_WR_RD: begin
				cmd.rd_word = 1'b1;
			end
			bpa_pkg::S_WR_WR: begin
				cmd.wr_word = 1'b1;
			end
			bpa_pkg::S_AL_CHK: begin
				priority if (stat.cnt_zero) begin
					cmd.pend_we   = 1'b1;
					cmd.pend_code = bpa_pkg::STAT_ZERO;
				end else if (stat.too_big) begin
					cmd.pend_we   = 1'b1;
					cmd.pend_code = bpa_pkg::STAT_NOFIT;
				end else begin
					cmd.sc_start = 1'b1;
				end
			end
			bpa_pkg::S_SC_RD: begin
				if (stat.sc_end) begin
					cmd.pend_we   = 1'b1;
					cmd.pend_code = bpa_pkg::STAT_NOFIT;
				end else begin
					cmd.rd_word = 1'b1;
				end
			end
			bpa_pkg::S_SC_LD: begin
				cmd.sc_load = 1'b1;
			end
			bpa_pkg::S_SC_EV: begin
				cmd.sc_eval = 1'b1;
				if (stat.found && stat.far) begin
					cmd.pend_we   = 1'b1;
					cmd.pend_code = bpa_pkg::STAT_NOFIT;
				end
			end
			bpa_pkg::S_RESP: begin
				cmd.res_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/bpa_datapath.sv
`default_nettype none

module bpa_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [bpa_pkg::MODE_W-1:0]    mode,
	input  wire logic [bpa_pkg::START_W-1:0]   first_page,
	input  wire logic [bpa_pkg::COUNT_W-1:0]   page_count,
	input  wire bpa_pkg::cmd_t                 cmd,
	output bpa_pkg::stat_t                     stat,
	output logic [bpa_pkg::STATUS_W-1:0]       status,
	output logic [bpa_pkg::START_W-1:0]        alloc_page
);

	localparam int W   = bpa_pkg::WORD_W;
	localparam int BW  = bpa_pkg::BIT_W;
	localparam int PW  = bpa_pkg::PG_W;
	localparam int XW  = bpa_pkg::WIDX_W;
	localparam int IW  = bpa_pkg::WORD_IDX_W;
	localparam logic [PW-1:0] LAST_PAGE = PW'(bpa_pkg::MAP_PAGES - 1);

	function automatic logic [BW-1:0] lowest_set(input logic [W-1:0] v);
		logic [BW-1:0] r;
		r = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = BW'(i);
			end
		end
		return r;
	endfunction

	logic [W-1:0]                   mem [bpa_pkg::NUM_WORDS];
	logic [bpa_pkg::NUM_WORDS-1:0]  valid_q;
	logic [W-1:0]                   rd_data_q;
	logic                           rd_valid_q;

	bpa_pkg::mode_t                 mode_q;
	logic [PW-1:0]                  start_q;
	logic [bpa_pkg::COUNT_W-1:0]    count_q;
	logic [PW-1:0]                  last_q;
	logic [bpa_pkg::LIMIT_W-1:0]    limit_q;
	logic [XW-1:0]                  widx_q;
	logic [W-1:0]                   word_q;
	logic [BW-1:0]                  pos_q;
	logic                           in_run_q;
	logic [PW-1:0]                  run_start_q;
	bpa_pkg::status_t               pend_q;
	bpa_pkg::status_t               status_q;
	logic [bpa_pkg::START_W-1:0]    page_q;

	logic [IW-1:0] addr;
	logic [W-1:0]  old_word;
	logic [PW-1:0] base;
	logic [PW-1:0] lim_ext;
	logic [PW-1:0] lim_diff;
	logic [W-1:0]  lim_mask;
	logic [W-1:0]  pos_mask;
	logic [W-1:0]  cand;
	logic          none;
	logic [BW-1:0] idx;
	logic [PW-1:0] end_excl;
	logic [PW-1:0] run_len;
	logic          found;
	logic [PW-1:0] last_raw;
	logic [PW-1:0] last_clip;
	logic [PW-1:0] new_lim;
	logic          empty;
	logic [XW-1:0] start_w;
	logic [XW-1:0] last_w;
	logic [BW-1:0] lo;
	logic [BW-1:0] hi;
	logic [W-1:0]  wmask;
	logic          set_bits;
	logic [W-1:0]  nxt_word;

	assign addr     = widx_q[IW-1:0];
	assign old_word = rd_valid_q ? rd_data_q : '1;
	assign base     = PW'({widx_q, {BW{1'b0}}});
	assign lim_ext  = PW'(limit_q);
	assign lim_diff = lim_ext - base;
	assign lim_mask = (lim_diff >= PW'(W)) ? '1 : ~({W{1'b1}} << lim_diff[BW-1:0]);

	assign pos_mask = {W{1'b1}} << pos_q;
	assign cand     = in_run_q ? (~word_q & pos_mask) : (word_q & pos_mask);
	assign none     = (cand == '0);
	assign idx      = lowest_set(cand);
	assign end_excl = base + (none ? PW'(W) : PW'(idx));
	assign run_len  = end_excl - run_start_q;
	assign found    = in_run_q && (run_len >= PW'(count_q));

	assign last_raw  = start_q + PW'(count_q) - PW'(1);
	assign last_clip = (last_raw > LAST_PAGE) ? LAST_PAGE : last_raw;
	assign new_lim   = last_clip + PW'(1);
	assign empty     = (count_q == '0) || (start_q > LAST_PAGE);

	assign start_w  = XW'(start_q >> BW);
	assign last_w   = XW'(last_q >> BW);
	assign lo       = (widx_q == start_w) ? start_q[BW-1:0] : '0;
	assign hi       = (widx_q == last_w) ? last_q[BW-1:0] : '1;
	assign wmask    = ({W{1'b1}} << lo) & ({W{1'b1}} >> (BW'(W - 1) - hi));
	assign set_bits = (mode_q == bpa_pkg::MODE_MARK) || (mode_q == bpa_pkg::MODE_ALLOC);
	assign nxt_word = set_bits ? (old_word | wmask) : (old_word & ~wmask);

	assign stat.in_alloc = (bpa_pkg::mode_t'(mode) == bpa_pkg::MODE_ALLOC);
	assign stat.empty    = empty;
	assign stat.wr_last  = (widx_q == last_w);
	assign stat.cnt_zero = (count_q == '0);
	assign stat.too_big  = (count_q > limit_q);
	assign stat.sc_end   = (base >= lim_ext);
	assign stat.found    = found;
	assign stat.far      = (run_start_q >= PW'(bpa_pkg::START_LIMIT));
	assign stat.ev_next  = none && !found;

	assign status     = status_q;
	assign alloc_page = page_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_word) begin
			rd_data_q  <= mem[addr];
			rd_valid_q <= valid_q[addr];
		end
		if (cmd.wr_word) begin
			mem[addr] <= nxt_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			limit_q <= '0;
		end else begin
			if (cmd.wr_word) begin
				valid_q[addr] <= 1'b1;
			end
			if (cmd.range_set && !empty && (mode_q == bpa_pkg::MODE_ADD) &&
				(new_lim > lim_ext)) begin
				limit_q <= new_lim[bpa_pkg::LIMIT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q  <= bpa_pkg::mode_t'(mode);
			start_q <= PW'(first_page);
			count_q <= page_count;
			pend_q  <= bpa_pkg::STAT_DONE;
		end
		if (cmd.pend_we) begin
			pend_q <= cmd.pend_code;
		end
		if (cmd.range_set) begin
			last_q <= last_clip;
			widx_q <= start_w;
		end
		if (cmd.wr_word) begin
			widx_q <= widx_q + XW'(1);
		end
		if (cmd.sc_start) begin
			widx_q   <= '0;
			pos_q    <= '0;
			in_run_q <= 1'b0;
		end
		if (cmd.sc_load) begin
			word_q <= ~old_word & lim_mask;
		end
		if (cmd.sc_eval) begin
			priority if (found) begin
				start_q <= run_start_q;
			end else if (none) begin
				widx_q <= widx_q + XW'(1);
				pos_q  <= '0;
			end else if (!in_run_q) begin
				run_start_q <= base + PW'(idx);
				in_run_q    <= 1'b1;
				pos_q       <= idx;
			end else begin
				in_run_q <= 1'b0;
				pos_q    <= idx;
			end
		end
		if (cmd.res_load) begin
			status_q <= pend_q;
			page_q   <= ((mode_q == bpa_pkg::MODE_ALLOC) && (pend_q == bpa_pkg::STAT_DONE)) ?
				start_q[bpa_pkg::START_W-1:0] : '0;
		end
	end

endmodule

`default_nettype wire

FILE: sv/bitmap_page_allocator.sv
// Channel  Role    Payload
// req      sink    mode, first_page, page_count
// rsp      source  status, alloc_page
//
// A range request sets its range, then reads and writes each 64-page bitmap word it touches.
// An alloc of zero pages or of more pages than the limit answers from its check state. Any other
// alloc scans each bitmap word below the limit with a read, a load and one evaluation per
// free-run boundary met in it plus one at its end; a failed scan ends in the response state,
// a granted run after a range write over it. The bitmap memory is single-port.
// After reset every word is marked unwritten and reads as all pages used, with no clearing pass.
// A finished result waits in the output register, and the block stalls only when the next
// result is ready before the previous one has been taken.
`default_nettype none

module bitmap_page_allocator (
	input wire logic clk,
	input wire logic arst_n,
	bpa_req_if.sink  req,
	bpa_rsp_if.source rsp
);

	bpa_pkg::cmd_t  cmd;
	bpa_pkg::stat_t stat;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	bpa_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (req.mode),
		.first_page (req.first_page),
		.page_count (req.page_count),
		.cmd        (cmd),
		.stat       (stat),
		.status     (rsp.status),
		.alloc_page (rsp.alloc_page)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("A second word was accepted while a request was in progress.");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_word |-> $past(cmd.rd_word))
		else $error("A bitmap word was written without being read the cycle before.");

	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sc_load |-> $past(cmd.rd_word))
		else $error("A scan word was loaded without a preceding read.");

	a_page_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != bpa_pkg::STAT_DONE) |-> (rsp.alloc_page == '0))
		else $error("A failed request returned a non-zero page.");

endmodule

`default_nettype wire

FILE: tb/sv/bitmap_page_allocator_test.sv
`default_nettype none

module bitmap_page_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bpa_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 2000;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		mode_t              mode;
		logic [START_W-1:0] first_page;
		logic [COUNT_W-1:0] page_count;
	} page_req_t;

	typedef struct packed {
		status_t            status;
		logic [START_W-1:0] alloc_page;
	} page_rsp_t;

	logic clk;
	logic arst_n;

	bpa_req_if req();
	bpa_rsp_if rsp();

	bitmap_page_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	page_req_t pending_req[$];
	page_rsp_t expected_rsp[$];
	page_req_t on_bus;
	page_rsp_t predicted;
	page_rsp_t oldest;

	bit               used_map [MAP_PAGES];
	logic [LIMIT_W-1:0] page_limit;

	int error_count;
	int sent_count;
	int checked_count;
	int cycle_count;
	int adds_seen;
	int marks_seen;
	int frees_seen;
	int allocs_granted;
	int allocs_refused;
	int allocs_zero;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic report_mismatch(input string what);
		if (error_count < MAX_PRINTED)
			$display("@%0t error: %s", $time, what);
		error_count++;
	endtask

	task automatic write_range(input int unsigned first, input int unsigned count,
		input bit used, input bit raise);
		int unsigned p;
		for (int unsigned i = 0; i < count; i++) begin
			p = first + i;
			if (p < MAP_PAGES) begin
				used_map[p] = used;
				if (raise && p >= page_limit)
					page_limit = LIMIT_W'(p + 1);
			end
		end
	endtask

	task automatic predict_request(input page_req_t rq, output page_rsp_t rs);
		int unsigned want;
		int unsigned run;
		int unsigned found_at;
		bit hit;
		want = rq.page_count;
		rs.status = STAT_DONE;
		rs.alloc_page = '0;
		case (rq.mode)
			MODE_ADD: begin
				write_range(rq.first_page, want, 1'b0, 1'b1);
				adds_seen++;
			end
			MODE_MARK: begin
				write_range(rq.first_page, want, 1'b1, 1'b0);
				marks_seen++;
			end
			MODE_FREE: begin
				write_range(rq.first_page, want, 1'b0, 1'b0);
				frees_seen++;
			end
			default: begin
				if (want == 0) begin
					rs.status = STAT_ZERO;
					allocs_zero++;
				end else if (want > page_limit) begin
					rs.status = STAT_NOFIT;
					allocs_refused++;
				end else begin
					run = 0;
					hit = 1'b0;
					found_at = 0;
					for (int unsigned p = 0; p < page_limit && !hit; p++) begin
						if (p >= MAP_PAGES || used_map[p]) begin
							run = 0;
						end else begin
							run++;
							if (run == want) begin
								found_at = p + 1 - want;
								hit = 1'b1;
							end
						end
					end
					if (hit && found_at < START_LIMIT) begin
						write_range(found_at, want, 1'b1, 1'b0);
						rs.alloc_page = START_W'(found_at);
						allocs_granted++;
					end else begin
						rs.status = STAT_NOFIT;
						allocs_refused++;
					end
				end
			end
		endcase
	endtask

	function automatic page_req_t make_req(mode_t m, int unsigned s, int unsigned c);
		page_req_t r;
		r.mode = m;
		r.first_page = START_W'(s);
		r.page_count = COUNT_W'(c);
		return r;
	endfunction

	task automatic queue_random(input int n, input int unsigned cap);
		int unsigned pick;
		int unsigned spread;
		int unsigned s;
		int unsigned c;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			spread = $urandom_range(0, 99);
			if (spread < 8)
				c = 0;
			else if (spread < 70)
				c = $urandom_range(1, 8);
			else if (spread < 92)
				c = $urandom_range(9, 64);
			else
				c = $urandom_range(65, cap);
			if (pick < 22) begin
				s = $urandom_range(0, cap - 1);
				if (c > cap - s)
					c = cap - s;
				pending_req.push_back(make_req(MODE_ADD, s, c));
			end else if (pick < 62) begin
				spread = $urandom_range(0, 99);
				if (spread < 15) begin
					s = $urandom_range(0, MAP_PAGES - 1);
					c = c % 65;
				end else if (spread < 22) begin
					s = $urandom_range(MAP_PAGES - 64, MAP_PAGES - 1);
					c = $urandom_range(1, 128);
				end else begin
					s = $urandom_range(0, cap - 1);
				end
				pending_req.push_back(make_req((pick < 38) ? MODE_MARK : MODE_FREE, s, c));
			end else begin
				if ($urandom_range(0, 99) < 5)
					c = $urandom_range(cap, MAP_PAGES);
				pending_req.push_back(make_req(MODE_ALLOC, $urandom_range(0, MAP_PAGES - 1), c));
			end
		end
	endtask

	// A new request word is loaded once the previous one has been taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.mode <= MODE_ADD;
			req.first_page <= '0;
			req.page_count <= '0;
		end else begin
			if (req.valid && req.ready) begin
				predict_request(on_bus, predicted);
				expected_rsp.push_back(predicted);
				sent_count++;
			end
			if (!req.valid || req.ready) begin
				if (pending_req.size() != 0 &&
					((sent_count >= 250 && sent_count < 400) || $urandom_range(0, 99) >= 13)) begin
					on_bus = pending_req.pop_front();
					req.mode <= on_bus.mode;
					req.first_page <= on_bus.first_page;
					req.page_count <= on_bus.page_count;
					req.valid <= 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch($sformatf(
						"result word with nothing expected: status %0d page %0d",
						rsp.status, rsp.alloc_page));
				end else begin
					oldest = expected_rsp.pop_front();
					if (rsp.status !== oldest.status)
						report_mismatch($sformatf("result %0d: status %0d, expected %0d",
							checked_count, rsp.status, oldest.status));
					if (rsp.alloc_page !== oldest.alloc_page)
						report_mismatch($sformatf("result %0d: alloc_page %0d, expected %0d",
							checked_count, rsp.alloc_page, oldest.alloc_page));
				end
				checked_count++;
			end
			rsp.ready <= (checked_count >= 250 && checked_count < 400) ||
				($urandom_range(0, 99) >= 13);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, expected_rsp.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.mode = MODE_ADD;
		req.first_page = '0;
		req.page_count = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		error_count = 0;
		sent_count = 0;
		checked_count = 0;
		cycle_count = 0;
		adds_seen = 0;
		marks_seen = 0;
		frees_seen = 0;
		allocs_granted = 0;
		allocs_refused = 0;
		allocs_zero = 0;
		foreach (used_map[i])
			used_map[i] = 1'b1;
		page_limit = '0;

		pending_req.push_back(make_req(MODE_ALLOC, 0, 0));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 1));
		pending_req.push_back(make_req(MODE_ADD, 0, 0));
		pending_req.push_back(make_req(MODE_MARK, 5, 0));
		pending_req.push_back(make_req(MODE_FREE, 5, 0));
		pending_req.push_back(make_req(MODE_ADD, 0, 64));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 64));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 1));
		pending_req.push_back(make_req(MODE_FREE, 0, 1));
		pending_req.push_back(make_req(MODE_FREE, 63, 1));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 2));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 1));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 1));
		pending_req.push_back(make_req(MODE_FREE, 16, 16));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 16));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 65));
		pending_req.push_back(make_req(MODE_FREE, MAP_PAGES - 4, 8));
		pending_req.push_back(make_req(MODE_MARK, MAP_PAGES - 1, 1));
		pending_req.push_back(make_req(MODE_ADD, 100, 28));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 29));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 28));
		pending_req.push_back(make_req(MODE_FREE, 0, 128));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 128));

		queue_random(280, 256);
		queue_random(220, 2048);
		queue_random(60, MAP_PAGES);

		pending_req.push_back(make_req(MODE_ADD, MAP_PAGES - 1, MAP_PAGES));
		pending_req.push_back(make_req(MODE_MARK, 0, MAP_PAGES));
		pending_req.push_back(make_req(MODE_ALLOC, MAP_PAGES - 1, 1));
		pending_req.push_back(make_req(MODE_FREE, 0, MAP_PAGES));
		pending_req.push_back(make_req(MODE_ALLOC, 0, MAP_PAGES));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 1));
		pending_req.push_back(make_req(MODE_FREE, MAP_PAGES - 1, 1));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 1));
		pending_req.push_back(make_req(MODE_ALLOC, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_req.size() != 0 || req.valid || expected_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d request words and checked %0d result words:",
			sent_count, checked_count);
		$display("%0d adds, %0d marks, %0d frees.", adds_seen, marks_seen, frees_seen);
		$display("Allocs: %0d granted, %0d refused, %0d zero-length; page limit ended at %0d.",
			allocs_granted, allocs_refused, allocs_zero, page_limit);
		if (error_count == 0 && expected_rsp.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches found.", error_count);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
